// File: design/tgc_pkg.sv
// Shared types, widths and codes for the touch gesture classifier.
// No dependencies; imported by every design file.
package tgc_pkg;

    localparam int COORD_BITS    = 12;
    localparam int TIME_BITS     = 32;
    localparam int MODE_BITS     = 3;
    localparam int KIND_BITS     = 3;
    localparam int SLOP_BITS     = 12;
    localparam int MS_BITS       = 16;
    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;
    localparam int REG_IDX_BITS  = 2;
    localparam int SPAN_BITS     = 2 * COORD_BITS + 1;
    localparam int SQ_CFG_BITS   = 2 * SLOP_BITS;
    localparam int CMP_BITS      = (SPAN_BITS > SQ_CFG_BITS) ? SPAN_BITS : SQ_CFG_BITS;

    localparam logic [SLOP_BITS-1:0] TAP_SLOP_RESET   = SLOP_BITS'(20);
    localparam logic [MS_BITS-1:0]   LONG_PRESS_RESET = MS_BITS'(500);
    localparam logic [MS_BITS-1:0]   SWIPE_MAX_RESET  = MS_BITS'(800);
    localparam logic [SLOP_BITS-1:0] SWIPE_MIN_RESET  = SLOP_BITS'(60);

    typedef enum logic [MODE_BITS-1:0] {
        MODE_DOWN   = 3'd0,
        MODE_MOVE   = 3'd1,
        MODE_UP     = 3'd2,
        MODE_CANCEL = 3'd3,
        MODE_KEY    = 3'd4,
        MODE_TICK   = 3'd5
    } tgc_mode_t;

    typedef enum logic [KIND_BITS-1:0] {
        GEST_TAP   = 3'd0,
        GEST_LONG  = 3'd1,
        GEST_LEFT  = 3'd2,
        GEST_RIGHT = 3'd3,
        GEST_UP    = 3'd4,
        GEST_DOWN  = 3'd5
    } tgc_gesture_t;

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_TAP_SLOP   = 2'd0,
        REG_LONG_PRESS = 2'd1,
        REG_SWIPE_MAX  = 2'd2,
        REG_SWIPE_MIN  = 2'd3
    } tgc_reg_t;

    typedef struct packed {
        logic [SLOP_BITS-1:0] tap_slop_px;
        logic [MS_BITS-1:0]   long_press_ms;
        logic [MS_BITS-1:0]   swipe_max_ms;
        logic [SLOP_BITS-1:0] swipe_min_px;
    } tgc_cfg_t;

    typedef struct packed {
        logic [MODE_BITS-1:0]  mode;
        logic [COORD_BITS-1:0] pos_x;
        logic [COORD_BITS-1:0] pos_y;
        logic [TIME_BITS-1:0]  time_ms;
    } tgc_event_t;

    typedef struct packed {
        logic [KIND_BITS-1:0]  gesture_kind;
        logic [COORD_BITS-1:0] start_x;
        logic [COORD_BITS-1:0] start_y;
        logic [TIME_BITS-1:0]  event_time_ms;
    } tgc_result_t;

endpackage

// File: design/touch_gesture_classifier.sv
// Touch gesture classifier top level: request and result registers around the core.
// Depends on tgc_pkg, tgc_cfg_regs and tgc_core.
//
// Usage:
//   Input channel in_valid/in_stall carries one touch request (mode, pos_x, pos_y,
//   time_ms). Output channel out_valid/out_stall carries one gesture (gesture_kind,
//   start_x, start_y, event_time_ms). A request moves on a rising edge with valid
//   high and stall low. Many requests (down, move, cancel, key, quiet ticks and
//   ups) produce no gesture.
//   Path: a request is registered in the input register, classified by the core,
//   and its gesture is registered in the output register.
//   Throughput: one request per cycle while no gesture waits under out_stall; the
//   classify stage reads and updates the touch state in the same cycle it runs.
//   Stall: while a gesture waits under out_stall, one more request is taken into
//   the input register; in_stall then rises until the gesture is taken.
//   Reset: rst_n clears the touch state and both pipeline valid flags and loads the
//   register defaults (slop 20, long press 500 ms, swipe max 800 ms, swipe min 60).
//   Registers are written over the APB port at byte addresses 0, 4, 8 and 12.
module touch_gesture_classifier (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [tgc_pkg::MODE_BITS-1:0]      mode,
    input  logic [tgc_pkg::COORD_BITS-1:0]     pos_x,
    input  logic [tgc_pkg::COORD_BITS-1:0]     pos_y,
    input  logic [tgc_pkg::TIME_BITS-1:0]      time_ms,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [tgc_pkg::KIND_BITS-1:0]      gesture_kind,
    output logic [tgc_pkg::COORD_BITS-1:0]     start_x,
    output logic [tgc_pkg::COORD_BITS-1:0]     start_y,
    output logic [tgc_pkg::TIME_BITS-1:0]      event_time_ms,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tgc_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [tgc_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [tgc_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                               pready
);
    import tgc_pkg::*;

    tgc_cfg_t    cfg;
    tgc_event_t  req_reg;
    logic        req_valid_reg;
    tgc_result_t out_reg;
    logic        out_valid_reg;
    tgc_result_t res;
    logic        res_fire;
    logic        advance;
    logic        core_en;

    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = req_valid_reg && !advance;
    assign core_en  = req_valid_reg && advance;

    tgc_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tgc_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .evt_en   (core_en),
        .evt      (req_reg),
        .res_fire (res_fire),
        .res      (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                req_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= core_en && res_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            req_reg.mode    <= mode;
            req_reg.pos_x   <= pos_x;
            req_reg.pos_y   <= pos_y;
            req_reg.time_ms <= time_ms;
        end
        if (core_en && res_fire)
            out_reg <= res;
    end

    assign out_valid     = out_valid_reg;
    assign gesture_kind  = out_reg.gesture_kind;
    assign start_x       = out_reg.start_x;
    assign start_y       = out_reg.start_y;
    assign event_time_ms = out_reg.event_time_ms;

endmodule

// File: design/tgc_cfg_regs.sv
// APB-style configuration registers for the touch gesture classifier.
// Depends on tgc_pkg.
module tgc_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tgc_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [tgc_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [tgc_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                               pready,
    output tgc_pkg::tgc_cfg_t                  cfg
);
    import tgc_pkg::*;

    tgc_cfg_t cfg_reg;
    tgc_reg_t reg_idx;
    logic     wr_en;

    assign reg_idx = tgc_reg_t'(paddr[REG_IDX_BITS+1:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tap_slop_px   <= TAP_SLOP_RESET;
            cfg_reg.long_press_ms <= LONG_PRESS_RESET;
            cfg_reg.swipe_max_ms  <= SWIPE_MAX_RESET;
            cfg_reg.swipe_min_px  <= SWIPE_MIN_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_TAP_SLOP:   cfg_reg.tap_slop_px   <= pwdata[SLOP_BITS-1:0];
                REG_LONG_PRESS: cfg_reg.long_press_ms <= pwdata[MS_BITS-1:0];
                REG_SWIPE_MAX:  cfg_reg.swipe_max_ms  <= pwdata[MS_BITS-1:0];
                REG_SWIPE_MIN:  cfg_reg.swipe_min_px  <= pwdata[SLOP_BITS-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_TAP_SLOP:   prdata = APB_DATA_BITS'(cfg_reg.tap_slop_px);
            REG_LONG_PRESS: prdata = APB_DATA_BITS'(cfg_reg.long_press_ms);
            REG_SWIPE_MAX:  prdata = APB_DATA_BITS'(cfg_reg.swipe_max_ms);
            REG_SWIPE_MIN:  prdata = APB_DATA_BITS'(cfg_reg.swipe_min_px);
            default:        prdata = '0;
        endcase
    end

endmodule

// File: design/tgc_core.sv
// Touch state and gesture classification for one registered request.
// Depends on tgc_pkg.
module tgc_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tgc_pkg::tgc_cfg_t     cfg,
    input  logic                  evt_en,
    input  tgc_pkg::tgc_event_t   evt,
    output logic                  res_fire,
    output tgc_pkg::tgc_result_t  res
);
    import tgc_pkg::*;

    logic                  pressed_reg, pressed_next;
    logic                  left_slop_reg, left_slop_next;
    logic                  long_rep_reg, long_rep_next;
    logic [COORD_BITS-1:0] origin_x_reg, origin_x_next;
    logic [COORD_BITS-1:0] origin_y_reg, origin_y_next;
    logic [TIME_BITS-1:0]  origin_t_reg, origin_t_next;

    logic signed [COORD_BITS:0] dx, dy;
    logic [COORD_BITS-1:0]      adx, ady;
    logic [2*COORD_BITS-1:0]    sq_x, sq_y;
    logic [SPAN_BITS-1:0]       span;
    logic [SQ_CFG_BITS-1:0]     slop_sq, min_sq;
    logic                       outside, too_short;
    logic                       t_before, long_due, tick_due, too_slow;
    logic [TIME_BITS-1:0]       diff, held;
    logic                       moved;
    tgc_gesture_t               kind;

    // geometry relative to the touch origin
    assign dx   = $signed({1'b0, evt.pos_x}) - $signed({1'b0, origin_x_reg});
    assign dy   = $signed({1'b0, evt.pos_y}) - $signed({1'b0, origin_y_reg});
    assign adx  = dx[COORD_BITS] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
    assign ady  = dy[COORD_BITS] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
    assign sq_x = adx * adx;
    assign sq_y = ady * ady;
    assign span = SPAN_BITS'(sq_x) + SPAN_BITS'(sq_y);

    assign slop_sq   = cfg.tap_slop_px * cfg.tap_slop_px;
    assign min_sq    = cfg.swipe_min_px * cfg.swipe_min_px;
    assign outside   = CMP_BITS'(span) > CMP_BITS'(slop_sq);
    assign too_short = CMP_BITS'(span) < CMP_BITS'(min_sq);

    // hold time
    assign t_before = evt.time_ms < origin_t_reg;
    assign diff     = evt.time_ms - origin_t_reg;
    assign held     = t_before ? '0 : diff;
    assign long_due = held >= TIME_BITS'(cfg.long_press_ms);
    assign tick_due = !t_before && long_due;
    assign too_slow = held > TIME_BITS'(cfg.swipe_max_ms);
    assign moved    = left_slop_reg || outside;

    always_comb
    begin
        if (adx >= ady)
            kind = dx[COORD_BITS] ? GEST_LEFT : GEST_RIGHT;
        else
            kind = dy[COORD_BITS] ? GEST_UP : GEST_DOWN;
    end

    always_comb
    begin
        pressed_next   = pressed_reg;
        left_slop_next = left_slop_reg;
        long_rep_next  = long_rep_reg;
        origin_x_next  = origin_x_reg;
        origin_y_next  = origin_y_reg;
        origin_t_next  = origin_t_reg;
        res_fire       = 1'b0;
        res.gesture_kind  = GEST_TAP;
        res.start_x       = origin_x_reg;
        res.start_y       = origin_y_reg;
        res.event_time_ms = evt.time_ms;

        if (evt_en)
        begin
            unique case (evt.mode)
                MODE_DOWN:
                begin
                    pressed_next   = 1'b1;
                    left_slop_next = 1'b0;
                    long_rep_next  = 1'b0;
                    origin_x_next  = evt.pos_x;
                    origin_y_next  = evt.pos_y;
                    origin_t_next  = evt.time_ms;
                end
                MODE_MOVE:
                begin
                    if (pressed_reg && outside)
                        left_slop_next = 1'b1;
                end
                MODE_UP:
                begin
                    if (pressed_reg)
                    begin
                        pressed_next = 1'b0;
                        if (!long_rep_reg)
                        begin
                            left_slop_next = moved;
                            if (!moved)
                            begin
                                res_fire         = 1'b1;
                                res.gesture_kind = long_due ? GEST_LONG : GEST_TAP;
                            end
                            else if (!too_slow && !too_short)
                            begin
                                res_fire         = 1'b1;
                                res.gesture_kind = kind;
                            end
                        end
                    end
                end
                MODE_CANCEL:
                    pressed_next = 1'b0;
                MODE_TICK:
                begin
                    if (pressed_reg && !left_slop_reg && !long_rep_reg && tick_due)
                    begin
                        long_rep_next    = 1'b1;
                        res_fire         = 1'b1;
                        res.gesture_kind = GEST_LONG;
                    end
                end
                default: ;  // key and unused codes
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressed_reg   <= 1'b0;
            left_slop_reg <= 1'b0;
            long_rep_reg  <= 1'b0;
            origin_x_reg  <= '0;
            origin_y_reg  <= '0;
            origin_t_reg  <= '0;
        end
        else
        begin
            pressed_reg   <= pressed_next;
            left_slop_reg <= left_slop_next;
            long_rep_reg  <= long_rep_next;
            origin_x_reg  <= origin_x_next;
            origin_y_reg  <= origin_y_next;
            origin_t_reg  <= origin_t_next;
        end
    end

endmodule

// File: design/tgc_checker.sv
// Port-level checks for the touch gesture classifier, bound to the top level.
// Depends on tgc_pkg and touch_gesture_classifier.
module tgc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_stall,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic [tgc_pkg::KIND_BITS-1:0]   gesture_kind,
    input logic [tgc_pkg::COORD_BITS-1:0]  start_x,
    input logic [tgc_pkg::COORD_BITS-1:0]  start_y,
    input logic [tgc_pkg::TIME_BITS-1:0]   event_time_ms
);
    import tgc_pkg::*;

    // a waiting gesture holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(gesture_kind)
            && $stable(start_x) && $stable(start_y) && $stable(event_time_ms))
        else $error("gesture changed while stalled");

    // input backs up only behind a stalled gesture
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a stalled gesture");

    // a fresh gesture comes from a request accepted into the input register before it
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("gesture without matching request");

endmodule

bind touch_gesture_classifier tgc_checker u_tgc_checker (.*);
